// ----- rtl/core/mbd_pkg.sv -----
// Shared types and constants for the multi-button debounce block.
// Holds the request and response beat formats, the register map and reset values.
// No dependencies.
package mbd_pkg;

   localparam int PIN_WIDTH    = 8;
   localparam int DEBOUNCE_W   = 8;
   localparam int PERIOD_W     = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Register map.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESYNC_PERIOD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PERIOD   = 2'd2;

   // Register reset values.
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TICKS_RESET = 8'd15;
   localparam logic [PERIOD_W-1:0]   RESYNC_PERIOD_RESET  = 16'd100;
   localparam logic [PERIOD_W-1:0]   FRAME_PERIOD_RESET   = 16'd20;

   typedef struct packed {
      logic [PIN_WIDTH-1:0] pin_levels;
      logic [PIN_WIDTH-1:0] edge_seen;
   } req_type;

   typedef struct packed {
      logic [PIN_WIDTH-1:0] button_states;
      logic                 frame_due;
   } rsp_type;

   // Per-tick control shared by all button lanes.
   typedef struct packed {
      logic step;
      logic resync;
   } lane_ctl_type;

endpackage

// ----- rtl/core/mbd_period.sv -----
// Free-running period counter that fires once every period steps.
// Uses mbd_pkg for the period width.
module mbd_period (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [mbd_pkg::PERIOD_W-1:0] period,
   output logic                         fire
);

   logic [mbd_pkg::PERIOD_W-1:0] count_ff;
   logic [mbd_pkg::PERIOD_W-1:0] count_in;
   logic [mbd_pkg::PERIOD_W:0]   count_inc;

   // A period of zero behaves like one since the incremented count always reaches it.
   always_comb begin
      count_inc = {1'b0, count_ff} + {{mbd_pkg::PERIOD_W{1'b0}}, 1'b1};
      fire      = (count_inc >= {1'b0, period});
      count_in  = fire ? '0 : count_inc[mbd_pkg::PERIOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/mbd_lane.sv -----
// One button lane: debounce wait counter and the stable pressed bit.
// Uses mbd_pkg for the lane control struct and counter width.
module mbd_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  mbd_pkg::lane_ctl_type          ctl,
   input  logic [mbd_pkg::DEBOUNCE_W-1:0] debounce_ticks,
   input  logic                           edge_seen,
   input  logic                           pressed_now,
   output logic                           stable_in
);

   logic [mbd_pkg::DEBOUNCE_W-1:0] wait_ff;
   logic [mbd_pkg::DEBOUNCE_W-1:0] wait_in;
   logic [mbd_pkg::DEBOUNCE_W-1:0] wait_loaded;
   logic                           stable_ff;
   logic                           busy;
   logic                           sample;

   // The pin is sampled when the countdown ends this tick, or on a resync tick
   // when the lane is left idle.
   always_comb begin
      wait_loaded = edge_seen ? debounce_ticks : wait_ff;
      busy        = (wait_loaded != '0);
      wait_in     = busy ? wait_loaded - 1'b1 : '0;
      sample      = (wait_in == '0) && (busy || ctl.resync);
      stable_in   = sample ? pressed_now : stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff   <= '0;
         stable_ff <= 1'b0;
      end else if (ctl.step) begin
         wait_ff   <= wait_in;
         stable_ff <= stable_in;
      end
   end

endmodule

// ----- rtl/core/multi_button_debounce_top.sv -----
// Top level of the multi-button debounce block: beat registers, CSRs, lanes, timers.
// Depends on mbd_pkg, mbd_lane and mbd_period.
//
// Each request beat is one timer tick carrying the raw active-low pin levels and
// the edge flags of up to eight buttons; each tick yields exactly one response
// beat with the debounced pressed state after the tick and a frame_due flag that
// marks the frame snapshot. The block takes one tick per clock cycle while
// rsp_stall is low: a beat is captured into an input register; when it
// advances, all lane counters, the resync timer and the frame timer update
// together and the result lands in the response register, which drives
// rsp_valid. The input register drains whenever the response register is
// empty or being taken, so a full-rate stream flows with no bubbles while
// rsp_stall is low. Registers are
// written through the csr_ port, which is always ready; they should only be
// changed while no tick is in flight. BUTTONS sets the number of lanes; lanes
// beyond the eight pins see a released pin and no edges, and only the lowest
// eight stable bits are reported.
module multi_button_debounce_top #(
   parameter int BUTTONS = 8
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  mbd_pkg::req_type                req_data,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mbd_pkg::rsp_type                rsp_data,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [mbd_pkg::DEBOUNCE_W-1:0] debounce_ticks_ff;
   logic [mbd_pkg::PERIOD_W-1:0]   resync_period_ff;
   logic [mbd_pkg::PERIOD_W-1:0]   frame_period_ff;

   // Input stage and response stage.
   logic                  in_valid_ff;
   mbd_pkg::req_type      in_data_ff;
   logic                  rsp_valid_ff;
   mbd_pkg::rsp_type      rsp_data_ff;
   mbd_pkg::rsp_type      rsp_data_in;

   logic                  advance;
   logic                  req_take;
   logic                  resync_fire;
   logic                  frame_fire;
   mbd_pkg::lane_ctl_type lane_ctl;
   logic [BUTTONS-1:0]    lane_edge;
   logic [BUTTONS-1:0]    lane_pressed;
   logic [BUTTONS-1:0]    lane_stable;
   logic [mbd_pkg::PIN_WIDTH-1:0] states_out;

   // The CSR port never back-pressures.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= mbd_pkg::DEBOUNCE_TICKS_RESET;
         resync_period_ff  <= mbd_pkg::RESYNC_PERIOD_RESET;
         frame_period_ff   <= mbd_pkg::FRAME_PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mbd_pkg::CSR_DEBOUNCE_TICKS: begin
               debounce_ticks_ff <= csr_wdata[mbd_pkg::DEBOUNCE_W-1:0];
            end
            mbd_pkg::CSR_RESYNC_PERIOD: begin
               resync_period_ff <= csr_wdata;
            end
            mbd_pkg::CSR_FRAME_PERIOD: begin
               frame_period_ff <= csr_wdata;
            end
            default: begin
               // Writes outside the register map are dropped.
            end
         endcase
      end
   end

   // The tick held in the input register is processed when the response
   // register can take its result this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // Both timers step once per processed tick; the resync decision feeds the
   // lanes in the same cycle, matching the edge-then-resync order of a tick.
   mbd_period u_resync_timer (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .period (resync_period_ff),
      .fire   (resync_fire)
   );

   mbd_period u_frame_timer (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .period (frame_period_ff),
      .fire   (frame_fire)
   );

   assign lane_ctl.step   = advance;
   assign lane_ctl.resync = resync_fire;

   // Lanes past the physical pins see a released pin and never an edge.
   for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
      if (i < mbd_pkg::PIN_WIDTH) begin : g_pin
         assign lane_edge[i]    = in_data_ff.edge_seen[i];
         assign lane_pressed[i] = ~in_data_ff.pin_levels[i];
      end else begin : g_nopin
         assign lane_edge[i]    = 1'b0;
         assign lane_pressed[i] = 1'b0;
      end

      mbd_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .ctl            (lane_ctl),
         .debounce_ticks (debounce_ticks_ff),
         .edge_seen      (lane_edge[i]),
         .pressed_now    (lane_pressed[i]),
         .stable_in      (lane_stable[i])
      );
   end

   // Report the lowest eight lanes; missing lanes read as released.
   for (genvar j = 0; j < mbd_pkg::PIN_WIDTH; j++) begin : g_out
      if (j < BUTTONS) begin : g_have
         assign states_out[j] = lane_stable[j];
      end else begin : g_none
         assign states_out[j] = 1'b0;
      end
   end

   assign rsp_data_in.button_states = states_out;
   assign rsp_data_in.frame_due     = frame_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
